FILE: design/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/rfbcs_pkg.sv
`default_nettype none

package rfbcs_pkg;

    localparam int NUM_BINS  = 64;
    localparam int MAX_ROWS  = 65536;
    localparam int OFS_DEPTH = NUM_BINS + 1;

    localparam int CMD_W   = 2;
    localparam int FLOPS_W = 40;
    localparam int ACNT_W  = 16;
    localparam int BIDX_W  = 7;
    localparam int BIN_W   = 6;
    localparam int DEST_W  = 16;
    localparam int CNT_W   = 17;
    localparam int LEN_W   = 6;

    localparam logic [BIN_W-1:0]  LONG_BIN   = 6'd63;
    localparam logic [BIN_W-1:0]  OVF_BIN    = 6'd32;
    localparam logic [ACNT_W-1:0] LONG_RESET = 16'd128;
    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_ROWS);
    localparam logic [DEST_W-1:0] DEST_MAX   = DEST_W'(MAX_ROWS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_COUNT = 2'd0,
        CMD_PLACE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [FLOPS_W-1:0]  row_flops;
        logic [ACNT_W-1:0]   a_count;
        logic [BIDX_W-1:0]   bin_index;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]    bin;
        logic                placed;
        logic [DEST_W-1:0]   dest_index;
        logic [CNT_W-1:0]    offset;
        logic                overflow;
    } t_out_item;

    // Classification of one row, handed from the classifier to the sequencer.
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             skip;
        logic             ovf;
    } t_cls;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, MAX_CNT}) ? MAX_CNT : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/rfbcs_ram.sv
`default_nettype none

module rfbcs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/rfbcs_classify.sv
`default_nettype none

module rfbcs_classify (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [rfbcs_pkg::FLOPS_W-1:0]  i_row_flops,
    input  logic [rfbcs_pkg::ACNT_W-1:0]   i_a_count,
    input  logic [rfbcs_pkg::ACNT_W-1:0]   i_long_row_count,
    output rfbcs_pkg::t_cls                o_cls
);

    import rfbcs_pkg::*;

    logic [FLOPS_W-1:0] flops_m1;
    logic [LEN_W-1:0]   len;
    t_cls               n_cls;
    t_cls               r_cls;

    // The bit length of flops - 1 is ceil(log2 flops); a flop count of one
    // gives length zero and so lands in bin 1 with no special case.
    always_comb begin
        flops_m1 = i_row_flops - FLOPS_W'(1);
        len      = '0;
        for (int k = 0; k < FLOPS_W; k++) begin
            if (flops_m1[k]) begin
                len = LEN_W'(k + 1);
            end
        end
    end

    always_comb begin
        n_cls = '0;
        priority if (i_row_flops == '0) begin
            n_cls.skip = 1'b1;
        end else if (i_a_count >= i_long_row_count) begin
            n_cls.bin = LONG_BIN;
        end else if (i_a_count <= ACNT_W'(1)) begin
            n_cls.bin = '0;
        end else begin
            n_cls.bin = BIN_W'(len + LEN_W'(1));
        end
        n_cls.ovf = !n_cls.skip && (n_cls.bin >= OVF_BIN) && (n_cls.bin != LONG_BIN);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cls <= n_cls;
        end
    end

    assign o_cls = r_cls;

endmodule

`default_nettype wire

FILE: design/row_flop_bin_counting_sort.sv
// Row binning for sparse matrix multiply as a two-pass counting sort.
// Input channel: i_valid / o_stall with one command per transfer on i_data.
// Output channel: o_valid / i_stall with exactly one result per command.
// Count (cmd 0) bumps the count of the row's bin; place (cmd 1) returns the
// row's stable destination index; read (cmd 2) returns a bin's start offset;
// clear (cmd 3) empties every bin. The user writes long_row_count through
// i_cfg_we / i_cfg_wdata while the block is idle; the block itself does not
// enforce this. One command is in flight at a time. Skipped, overflowing and
// clear commands go from dispatch straight to the done state; the others
// first pass the update state. The first place or read after a count or
// clear first sweeps the 64 bins to build the prefix offsets, one bin per
// cycle through the count memory. A new transfer is taken once the result
// has moved to the output register. A finished result waits in the output
// register while i_stall is high; the block still accepts the next command
// meanwhile. Reset empties all bins, marks the offsets stale and sets
// long_row_count to 128.
`default_nettype none

module row_flop_bin_counting_sort (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  rfbcs_pkg::t_in_item             i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output rfbcs_pkg::t_out_item            o_data,
    input  logic                            i_cfg_we,
    input  logic [rfbcs_pkg::ACNT_W-1:0]    i_cfg_wdata
);

    import rfbcs_pkg::*;

    localparam int WAW = $clog2(NUM_BINS);
    localparam int OAW = $clog2(OFS_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_BUILD,
        S_UPD,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [BIDX_W-1:0]     r_bidx, n_bidx;
    logic [ACNT_W-1:0]     r_cfg, n_cfg;
    logic                  r_ready, n_ready;
    logic [NUM_BINS-1:0]   r_vld, n_vld;
    logic [OAW-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]      r_acc, n_acc;
    logic [WAW-1:0]        r_wq, n_wq;
    t_out_item             r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    t_cls                  cls;
    logic                  accept;

    // Word memory holds {count, fill} per bin; offset memory holds 65 offsets.
    logic                  w_we, w_re;
    logic [WAW-1:0]        w_waddr, w_raddr;
    logic [2*CNT_W-1:0]    w_wdata, w_rdata;
    logic                  f_we, f_re;
    logic [OAW-1:0]        f_waddr, f_raddr;
    logic [CNT_W-1:0]      f_wdata, f_rdata;

    logic [CNT_W-1:0]      rd_cnt, rd_fill, sum;
    logic [CNT_W:0]        d_sum;

    assign accept = (r_state == S_IDLE) && i_valid;

    rfbcs_classify u_classify (
        .i_clk            (i_clk),
        .i_en             (accept),
        .i_row_flops      (i_data.row_flops),
        .i_a_count        (i_data.a_count),
        .i_long_row_count (r_cfg),
        .o_cls            (cls)
    );

    rfbcs_ram #(
        .WIDTH (2 * CNT_W),
        .DEPTH (NUM_BINS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rfbcs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (OFS_DEPTH)
    ) u_ofs_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // A bin whose valid bit is clear has been emptied and reads as zero.
    assign rd_cnt  = r_vld[r_wq] ? w_rdata[2*CNT_W-1:CNT_W] : '0;
    assign rd_fill = r_vld[r_wq] ? w_rdata[CNT_W-1:0] : '0;
    assign sum     = sat_add(r_acc, rd_cnt);
    assign d_sum   = {1'b0, f_rdata} + {1'b0, rd_fill};

    // Only one command is in flight, and each bin that is read is written back
    // before it is read again, so no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_bidx      = r_bidx;
        n_cfg       = i_cfg_we ? i_cfg_wdata : r_cfg;
        n_ready     = r_ready;
        n_vld       = r_vld;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_wq        = r_wq;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;

        w_we    = 1'b0;
        w_waddr = r_wq;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = cls.bin;
        f_we    = 1'b0;
        f_waddr = r_idx;
        f_wdata = '0;
        f_re    = 1'b0;
        f_raddr = {1'b0, cls.bin};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_data.cmd;
                    n_bidx  = (i_data.bin_index > BIDX_W'(NUM_BINS)) ?
                              BIDX_W'(NUM_BINS) : i_data.bin_index;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res = '0;
                unique case (r_cmd)
                    CMD_CLEAR: begin
                        n_vld   = '0;
                        n_ready = 1'b0;
                        n_state = S_DONE;
                    end
                    CMD_COUNT, CMD_PLACE: begin
                        n_res.bin      = cls.bin;
                        n_res.overflow = cls.ovf;
                        priority if (cls.skip || cls.ovf) begin
                            n_state = S_DONE;
                        end else if (r_cmd == CMD_PLACE && !r_ready) begin
                            n_idx   = '0;
                            n_state = S_BUILD;
                        end else begin
                            w_re    = 1'b1;
                            f_re    = 1'b1;
                            n_wq    = cls.bin;
                            n_state = S_UPD;
                        end
                    end
                    CMD_READ: begin
                        if (!r_ready) begin
                            n_idx   = '0;
                            n_state = S_BUILD;
                        end else begin
                            f_re    = 1'b1;
                            f_raddr = r_bidx;
                            n_state = S_UPD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BUILD: begin
                // Read bin idx while the bin read last cycle is summed and
                // written back with its fill cleared.
                if (r_idx < OAW'(NUM_BINS)) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx[WAW-1:0];
                    n_wq    = r_idx[WAW-1:0];
                end
                f_we = 1'b1;
                if (r_idx == '0) begin
                    f_wdata = '0;
                    n_acc   = '0;
                end else begin
                    f_wdata     = sum;
                    n_acc       = sum;
                    w_we        = 1'b1;
                    w_wdata     = {rd_cnt, {CNT_W{1'b0}}};
                    n_vld[r_wq] = 1'b1;
                end
                if (r_idx == OAW'(NUM_BINS)) begin
                    n_ready = 1'b1;
                    n_state = S_DISPATCH;
                end else begin
                    n_idx = r_idx + OAW'(1);
                end
            end
            S_UPD: begin
                unique case (r_cmd)
                    CMD_COUNT: begin
                        w_we         = 1'b1;
                        w_wdata      = {sat_add(rd_cnt, CNT_W'(1)), rd_fill};
                        n_vld[r_wq]  = 1'b1;
                        n_ready      = 1'b0;
                        n_res.placed = 1'b1;
                    end
                    CMD_PLACE: begin
                        w_we         = 1'b1;
                        w_wdata      = {rd_cnt, sat_add(rd_fill, CNT_W'(1))};
                        n_vld[r_wq]  = 1'b1;
                        n_res.placed = 1'b1;
                        n_res.dest_index = (d_sum > {2'b00, DEST_MAX}) ?
                                           DEST_MAX : d_sum[DEST_W-1:0];
                    end
                    CMD_READ: begin
                        n_res.offset = f_rdata;
                    end
                    default: begin
                        n_res = r_res;
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= LONG_RESET;
            r_ready     <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_ready     <= n_ready;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_bidx <= n_bidx;
        r_idx  <= n_idx;
        r_acc  <= n_acc;
        r_wq   <= n_wq;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

FILE: design/rfbcs_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rfbcs_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input rfbcs_pkg::t_out_item   o_data
);

    import rfbcs_pkg::*;

    // Only one command is worked on at a time: a transfer closes the input.
    `ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // A row that overflows its bin is never counted or placed.
    `ASSERT_IMP(a_ovf_not_placed, i_clk, i_rst_n, o_valid && o_data.overflow, !o_data.placed)

    // A destination index only comes with a placed row.
    `ASSERT_IMP(a_dest_needs_place, i_clk, i_rst_n, o_valid && !o_data.placed,
                o_data.dest_index == '0)

    // A waiting result holds until it is taken.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

endmodule

bind row_flop_bin_counting_sort rfbcs_checker u_rfbcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

FILE: tb/row_flop_bin_counting_sort_tb.sv
module row_flop_bin_counting_sort_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfbcs_pkg::*;

    // Tracks the bins, their start offsets and the fill of each bin, and keeps the
    // results that the block still owes, oldest first.
    class bin_queue_checker;
        logic [ACNT_W-1:0] long_rows;
        logic [CNT_W-1:0]  bin_count [NUM_BINS];
        logic [CNT_W-1:0]  bin_start [OFS_DEPTH];
        logic [CNT_W-1:0]  bin_fill  [NUM_BINS];
        bit                starts_valid;
        t_out_item         due_results [$];
        int                failures;
        int                checked;

        function new();
            long_rows = LONG_RESET;
            failures  = 0;
            checked   = 0;
            empty_bins();
        endfunction

        function void empty_bins();
            foreach (bin_count[k]) bin_count[k] = '0;
            foreach (bin_start[k]) bin_start[k] = '0;
            foreach (bin_fill[k]) bin_fill[k] = '0;
            starts_valid = 1'b0;
        endfunction

        function logic [CNT_W-1:0] sat_rows(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
            int unsigned s;
            s = a + b;
            if (s > MAX_ROWS) s = MAX_ROWS;
            return CNT_W'(s);
        endfunction

        // Only called for rows with a nonzero flop count.
        function logic [BIN_W-1:0] choose_bin(logic [FLOPS_W-1:0] f, logic [ACNT_W-1:0] a);
            logic [FLOPS_W-1:0] v;
            int                 len;
            if (a >= long_rows) return LONG_BIN;
            if (a <= 1) return '0;
            if (f == 1) return BIN_W'(1);
            v   = f - 1;
            len = 0;
            while (v != 0) begin
                len++;
                v = v >> 1;
            end
            return BIN_W'(len + 1);
        endfunction

        function void refresh_starts();
            if (starts_valid) return;
            bin_start[0] = '0;
            for (int t = 1; t <= NUM_BINS; t++)
                bin_start[t] = sat_rows(bin_start[t-1], bin_count[t-1]);
            foreach (bin_fill[k]) bin_fill[k] = '0;
            starts_valid = 1'b1;
        endfunction

        function void note_command(t_in_item it);
            t_out_item         r;
            logic [BIN_W-1:0]  b;
            logic [CNT_W-1:0]  d;
            int unsigned       idx;
            r = '0;
            case (it.cmd)
                CMD_COUNT, CMD_PLACE: if (it.row_flops != 0) begin
                    b     = choose_bin(it.row_flops, it.a_count);
                    r.bin = b;
                    if (b >= OVF_BIN && b != LONG_BIN) begin
                        r.overflow = 1'b1;
                    end else if (it.cmd == CMD_COUNT) begin
                        r.placed     = 1'b1;
                        bin_count[b] = sat_rows(bin_count[b], CNT_W'(1));
                        starts_valid = 1'b0;
                    end else begin
                        refresh_starts();
                        r.placed = 1'b1;
                        d = sat_rows(bin_start[b], bin_fill[b]);
                        if (d > DEST_MAX) d = DEST_MAX;
                        r.dest_index = d[DEST_W-1:0];
                        bin_fill[b]  = sat_rows(bin_fill[b], CNT_W'(1));
                    end
                end
                CMD_READ: begin
                    idx = (it.bin_index > NUM_BINS) ? NUM_BINS : it.bin_index;
                    refresh_starts();
                    r.offset = bin_start[idx];
                end
                default: empty_bins();
            endcase
            due_results = {due_results, r};
        endfunction

        function string show(t_out_item r);
            return $sformatf("bin=%0d placed=%0d dest=%0d offset=%0d ovf=%0d",
                             r.bin, r.placed, r.dest_index, r.offset, r.overflow);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            checked++;
            if (due_results.size() == 0) begin
                flag({"Result arrived with none outstanding: ", show(got)});
                return;
            end
            want = due_results.pop_front();
            if (got.bin !== want.bin || got.placed !== want.placed ||
                got.dest_index !== want.dest_index || got.offset !== want.offset ||
                got.overflow !== want.overflow)
                flag($sformatf("Result %0d mismatch: expected %s, got %s",
                               checked, show(want), show(got)));
        endfunction

        function void close_out();
            if (due_results.size() != 0)
                flag($sformatf("%0d results never arrived", due_results.size()));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in_item             i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out_item            o_data;
    logic                 i_cfg_we = 1'b0;
    logic [ACNT_W-1:0]    i_cfg_wdata = '0;

    bin_queue_checker sb = new();

    bit gaps_on  = 1'b0;
    bit stall_on = 1'b0;
    int stall_left = 0;
    bit stall_next;
    int sent_total = 0;
    int sent_by_cmd [4] = '{0, 0, 0, 0};
    int settings_used = 1;

    row_flop_bin_counting_sort dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.long_rows = i_cfg_wdata;
            if (i_valid && !o_stall) sb.note_command(i_data);
            if (o_valid && !i_stall) sb.check_output(o_data);
        end
    end

    // Receiver back-pressure in bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_stall <= stall_next;
    end

    // Entered and left at a falling edge; holds the payload until the transfer.
    task automatic send_cmd(t_in_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = it;
        do @(posedge i_clk); while (o_stall);
        sent_total++;
        sent_by_cmd[it.cmd]++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(t_cmd c, logic [FLOPS_W-1:0] f, logic [ACNT_W-1:0] a,
                               logic [BIDX_W-1:0] x);
        t_in_item it;
        it.cmd       = c;
        it.row_flops = f;
        it.a_count   = a;
        it.bin_index = x;
        send_cmd(it);
    endtask

    function automatic t_in_item noise_item();
        t_in_item it;
        it.cmd       = t_cmd'($urandom_range(0, 3));
        it.row_flops = {8'($urandom), 32'($urandom)};
        it.a_count   = 16'($urandom);
        it.bin_index = 7'($urandom);
        return it;
    endfunction

    // Flop counts spread over every bit length, A counts clustered
    // around the single-row and long-row boundaries.
    function automatic t_in_item random_row(t_cmd c);
        t_in_item it;
        int       n;
        it           = noise_item();
        it.cmd       = c;
        it.row_flops = it.row_flops >> $urandom_range(0, 40);
        case ($urandom_range(0, 3))
            0: it.a_count = 16'($urandom_range(0, 2));
            1: begin
                n = sb.long_rows;
                n = n + int'($urandom_range(0, 2)) - 1;
                if (n < 0) n = 0;
                if (n > 65535) n = 65535;
                it.a_count = 16'(n);
            end
            2: it.a_count = 16'($urandom_range(2, 200));
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in_item read_item();
        t_in_item it;
        it     = noise_item();
        it.cmd = CMD_READ;
        if ($urandom_range(0, 3) != 0) it.bin_index = 7'($urandom_range(0, NUM_BINS));
        return it;
    endfunction

    // Mostly a full count / read / place sequence; now and then a short run of noise.
    task automatic run_batch();
        t_in_item rows [$];
        t_in_item it;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 5)) send_cmd(noise_item());
            return;
        end
        if ($urandom_range(0, 1) == 0) begin
            it     = noise_item();
            it.cmd = CMD_CLEAR;
            send_cmd(it);
        end
        repeat ($urandom_range(1, 30)) begin
            it = random_row(CMD_COUNT);
            rows = {rows, it};
            send_cmd(it);
        end
        repeat ($urandom_range(0, 3)) send_cmd(read_item());
        foreach (rows[k]) begin
            case ($urandom_range(0, 9))
                0: ;
                1: send_cmd(random_row(CMD_PLACE));
                2: send_cmd(read_item());
                default: begin
                    it           = rows[k];
                    it.cmd       = CMD_PLACE;
                    it.bin_index = 7'($urandom);
                    send_cmd(it);
                end
            endcase
        end
        repeat ($urandom_range(1, 3)) send_cmd(read_item());
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (sb.due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_long_rows(logic [ACNT_W-1:0] value);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [ACNT_W-1:0] plan [$];
        int                target;
        plan = '{16'd0, 16'd65535, 16'd1, 16'd2, 16'($urandom_range(3, 400)),
                 16'($urandom), 16'd128};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed checks under the reset threshold of 128.
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_fields(CMD_READ,  40'd0, 16'd0, 7'd0);
        send_fields(CMD_COUNT, 40'd0, 16'd5, 7'd0);
        send_fields(CMD_COUNT, 40'd1, 16'd2, 7'd0);
        send_fields(CMD_COUNT, 40'd2, 16'd2, 7'd0);
        send_fields(CMD_COUNT, 40'd3, 16'd3, 7'd0);
        send_fields(CMD_COUNT, '1, 16'd1, 7'd0);
        send_fields(CMD_COUNT, 40'd1, 16'd0, 7'd0);
        send_fields(CMD_COUNT, 40'd5, 16'd128, 7'd0);
        send_fields(CMD_COUNT, '1, '1, '1);
        send_fields(CMD_COUNT, 40'h40000000, 16'd127, 7'd0);
        send_fields(CMD_COUNT, 40'h40000001, 16'd2, 7'd0);
        send_fields(CMD_COUNT, '1, 16'd5, 7'd0);
        send_fields(CMD_READ,  40'd0, 16'd0, 7'd64);
        send_fields(CMD_READ,  '1, '1, 7'd127);
        send_fields(CMD_READ,  40'd0, 16'd0, 7'd3);
        send_fields(CMD_PLACE, 40'd1, 16'd2, 7'd0);
        // A second row into bin 1 was never counted and runs into bin 2's space.
        send_fields(CMD_PLACE, 40'd1, 16'd2, 7'd0);
        send_fields(CMD_PLACE, 40'h40000000, 16'd127, 7'd0);
        send_fields(CMD_PLACE, 40'd5, 16'd128, 7'd0);
        send_fields(CMD_PLACE, 40'd0, 16'd7, 7'd0);
        send_fields(CMD_PLACE, '1, 16'd5, 7'd0);
        send_fields(CMD_COUNT, 40'd3, 16'd3, 7'd0);
        send_fields(CMD_READ,  40'd0, 16'd0, 7'd64);
        send_fields(CMD_CLEAR, '1, '1, '1);
        send_fields(CMD_READ,  40'd0, 16'd0, 7'd64);

        target = sent_total;
        foreach (plan[p]) begin
            write_long_rows(plan[p]);
            target += 160;
            while (sent_total < target) begin
                if (p == plan.size() - 1) begin
                    gaps_on  = 1'b0;
                    stall_on = 1'b0;
                end else begin
                    gaps_on  = ($urandom_range(0, 4) != 0);
                    stall_on = ($urandom_range(0, 4) != 0);
                end
                run_batch();
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        sb.close_out();

        $display("Sent %0d commands: %0d count, %0d place, %0d read, %0d clear.",
                 sent_total, sent_by_cmd[CMD_COUNT], sent_by_cmd[CMD_PLACE],
                 sent_by_cmd[CMD_READ], sent_by_cmd[CMD_CLEAR]);
        $display("Checked %0d results across %0d long-row thresholds; %0d failures.",
                 sb.checked, settings_used, sb.failures);
        if (sb.failures == 0)
            $display("row_flop_bin_counting_sort test passed");
        else
            $display("row_flop_bin_counting_sort test failed");
        $finish;
    end

    initial begin
        #12ms;
        $display("Timed out with %0d results outstanding.", sb.due_results.size());
        $display("row_flop_bin_counting_sort test failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/rfbcs_pkg.sv
design/rfbcs_ram.sv
design/rfbcs_classify.sv
design/row_flop_bin_counting_sort.sv
design/rfbcs_checker.sv
tb/row_flop_bin_counting_sort_tb.sv
